// ===== design/vhe_pkg.sv =====
// Shared constants for the video histogram equalizer.
`default_nettype none
package vhe_pkg;
	localparam int LEVELS   = 256;
	localparam int LEVEL_W  = 8;
	localparam int CNT_W    = 22;
	localparam int SIDE_W   = 11;
	localparam int MAX_SIDE = 2047;
	localparam int NUM_W    = CNT_W + LEVEL_W;
	localparam int PIX_W    = 24;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;
endpackage
`default_nettype wire

// ===== design/video_histogram_equalizer_unit.sv =====
// Luma histogram equalizer: RGB in, YUV remap through the last frame's CDF, RGB out.
// A new input word is taken only after the previous result word has been loaded.
// Each pixel passes through a 9-step quotient loop before its result word is formed.
// On the last pixel of a frame a sweep builds the CDF memory from the
// histogram memory and clears it; no input word is taken during the sweep.
// Reset clears control state, then a pass zeroes both memories before input.
`default_nettype none
module video_histogram_equalizer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output      logic                        s_axis_tready,
	input  wire logic [vhe_pkg::PIX_W-1:0]   s_axis_tdata,  // in_red, in_green, in_blue
	output      logic                        m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output      logic [vhe_pkg::PIX_W-1:0]   m_axis_tdata,  // out_red, out_green, out_blue
	output      logic                        m_axis_tlast,  // frame_done
	input  wire logic                        cfg_we,
	input  wire logic [0:0]                  cfg_index,
	input  wire logic [vhe_pkg::SIDE_W-1:0]  cfg_data
);
	localparam int CW = vhe_pkg::CNT_W;
	localparam int LW = vhe_pkg::LEVEL_W;
	localparam int NW = vhe_pkg::NUM_W;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_YUV, S_RD, S_DIV0, S_DIV, S_CONV, S_SWEEP
	} state_t;

	state_t               state_q;
	logic [vhe_pkg::SIDE_W-1:0] width_q, height_q;
	logic [CW-1:0]        pos_q, total_q, den_q, acc_q;
	logic [7:0]           r_q, g_q, b_q, y_q;
	logic signed [9:0]    d_q, e_q;
	logic                 done_q, zero_q;
	logic [NW-1:0]        rem_q;
	logic [8:0]           quo_q;
	logic [3:0]           step_q;
	logic [LW:0]          sw_q;
	logic                 sw_v_s1;
	logic [LW-1:0]        sw_a_s1;
	logic [CW-1:0]        hist_mem [vhe_pkg::LEVELS];
	logic [CW-1:0]        cdf_mem [vhe_pkg::LEVELS];
	logic [CW-1:0]        hist_rd, cdf_rd;

	// Front-end products
	logic [CW-1:0]        total_w;
	logic [CW:0]          pos_inc;
	logic signed [17:0]   rs, gs, bs, sy, su, sv;
	assign total_w = CW'(width_q * height_q);
	assign pos_inc = {1'b0, pos_q} + (CW+1)'(1);
	assign rs = $signed({10'd0, r_q});
	assign gs = $signed({10'd0, g_q});
	assign bs = $signed({10'd0, b_q});
	assign sy = 18'sd66 * rs + 18'sd129 * gs + 18'sd25 * bs + 18'sd128;
	assign su = -18'sd38 * rs - 18'sd74 * gs + 18'sd112 * bs + 18'sd128;
	assign sv = 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs + 18'sd128;

	// Quotient step
	logic [NW-1:0]        den_sh;
	logic                 q_bit;
	assign den_sh = {{LW{1'b0}}, den_q} << step_q;
	assign q_bit  = rem_q >= den_sh;

	// Back conversion
	logic [7:0]           yeq;
	logic signed [19:0]   cc, ro, go, bo;
	logic [CW-1:0]        cdf_m1;
	assign yeq = zero_q ? 8'd0 : (quo_q[8] ? 8'd255 : quo_q[7:0]);
	assign cc = $signed({12'd0, yeq}) - 20'sd16;
	assign ro = (20'sd298 * cc + 20'sd409 * 20'(e_q) + 20'sd128) >>> 8;
	assign go = (20'sd298 * cc - 20'sd100 * 20'(d_q) - 20'sd208 * 20'(e_q) + 20'sd128) >>> 8;
	assign bo = (20'sd298 * cc + 20'sd516 * 20'(d_q) + 20'sd128) >>> 8;
	assign cdf_m1 = cdf_rd - CW'(1);

	function automatic logic [7:0] clip8(input logic signed [19:0] v);
		logic [7:0] res;
		if (v < 0) res = 8'd0;
		else if (v > 20'sd255) res = 8'd255;
		else res = v[7:0];
		return res;
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);

	// Output word is loaded once the register is free or being drained
	logic out_load;
	assign out_load = (state_q == S_CONV) && (!m_axis_tvalid || m_axis_tready);

	// Memory port control
	logic          h_we, c_we;
	logic [LW-1:0] h_wa, c_wa, rd_a;
	logic [CW-1:0] h_wd, c_wd, acc_n;
	assign acc_n = acc_q + hist_rd;
	always_comb begin
		h_we = 1'b0; h_wa = y_q; h_wd = hist_rd + CW'(1);
		c_we = 1'b0; c_wa = sw_a_s1; c_wd = acc_n;
		rd_a = y_q;
		if (state_q == S_DIV0) begin
			h_we = 1'b1;
		end else if (state_q == S_SWEEP || state_q == S_CLR) begin
			rd_a = sw_q[LW-1:0];
			h_we = !sw_q[LW];
			h_wa = sw_q[LW-1:0];
			h_wd = '0;
			c_we = sw_v_s1;
			if (state_q == S_CLR) c_wd = '0;
		end
	end

	// Histogram memory
	always_ff @(posedge clk) begin
		hist_rd <= hist_mem[rd_a];
		if (h_we) hist_mem[h_wa] <= h_wd;
	end

	// CDF memory
	always_ff @(posedge clk) begin
		cdf_rd <= cdf_mem[rd_a];
		if (c_we) cdf_mem[c_wa] <= c_wd;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= vhe_pkg::SIDE_W'(640);
			height_q <= vhe_pkg::SIDE_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				vhe_pkg::REG_WIDTH:  width_q  <= cfg_data;
				vhe_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			pos_q         <= '0;
			sw_q          <= '0;
			sw_v_s1       <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (out_load) m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			sw_v_s1 <= (state_q == S_SWEEP || state_q == S_CLR) && !sw_q[LW];
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						r_q     <= s_axis_tdata[7:0];
						g_q     <= s_axis_tdata[15:8];
						b_q     <= s_axis_tdata[23:16];
						total_q <= total_w;
						done_q  <= pos_inc >= {1'b0, total_w};
						pos_q   <= (pos_inc >= {1'b0, total_w}) ? '0 : pos_inc[CW-1:0];
						state_q <= S_YUV;
					end
				end
				S_YUV: begin
					y_q     <= 8'(sy >>> 8) + 8'd16;
					d_q     <= 10'(su >>> 8);
					e_q     <= 10'(sv >>> 8);
					state_q <= S_RD;
				end
				S_RD: state_q <= S_DIV0;
				S_DIV0: begin
					zero_q  <= (cdf_rd == '0) || (total_q <= CW'(1));
					rem_q   <= {cdf_m1, {LW{1'b0}}} - {{LW{1'b0}}, cdf_m1};
					den_q   <= total_q - CW'(1);
					quo_q   <= '0;
					step_q  <= 4'd8;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (q_bit) rem_q <= rem_q - den_sh;
					quo_q <= {quo_q[7:0], q_bit};
					if (step_q == 4'd0) state_q <= S_CONV;
					else step_q <= step_q - 4'd1;
				end
				S_CONV: begin
					if (out_load) begin
						m_axis_tdata  <= {clip8(bo), clip8(go), clip8(ro)};
						m_axis_tlast  <= done_q;
						sw_q          <= '0;
						acc_q         <= '0;
						state_q       <= done_q ? S_SWEEP : S_IDLE;
					end
				end
				S_SWEEP, S_CLR: begin
					// read level k; in the next cycle add it and store the running sum (zero in S_CLR)
					if (!sw_q[LW]) begin
						sw_q    <= sw_q + (LW+1)'(1);
						sw_a_s1 <= sw_q[LW-1:0];
					end
					if (sw_v_s1) acc_q <= acc_n;
					if (sw_q[LW] && !sw_v_s1) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
